// ===== src/ubpw_pkg.sv =====
// ----------------------------------------------------------------------------
// ubpw_pkg: shared definitions for the bit repacker
// Register map, field widths and small width helpers.
// ----------------------------------------------------------------------------
package ubpw_pkg;

  localparam int unsigned CHUNK_W = 8;   // input byte
  localparam int unsigned WORD_W  = 8;   // packed word
  localparam int unsigned CNT_W   = 3;   // held bit count
  localparam int unsigned WID_W   = 4;   // width registers
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [1:0] {
    REG_CHUNK_BITS  = 2'd0,
    REG_OUTPUT_BITS = 2'd1,
    REG_LSB_FIRST   = 2'd2
  } reg_idx_t;

  // 0 acts as 1, above 8 acts as 8
  function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] w);
    logic [WID_W-1:0] r;
    if (w == '0) begin
      r = WID_W'(1);
    end else if (w > WID_W'(WORD_W)) begin
      r = WID_W'(WORD_W);
    end else begin
      r = w;
    end
    return r;
  endfunction

  // low n bits set, n in 0..8
  function automatic logic [WORD_W-1:0] low_mask(input logic [WID_W-1:0] n);
    logic [2*WORD_W-1:0] m;
    m = (WORD_W*2)'(1) << n;
    m = m - (WORD_W*2)'(1);
    return m[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] rev_word(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = v[WORD_W-1-i];
    end
    return r;
  endfunction

endpackage

// ===== src/unpacked_bits_to_packed_word.sv =====
// ----------------------------------------------------------------------------
// unpacked_bits_to_packed_word
// Joins the low chunk_bits bits of each input byte into a bit stream and
// emits a packed word of output_bits bits each time enough bits are gathered.
//
// Input channel : chunk_valid / chunk_ready / in_chunk. One byte per item,
//                 low chunk_bits bits taken, MSB of the chunk first.
// Output channel: word_valid / word_ready / packed_value. Zero or one word
//                 per input item, unused upper bits zero.
// Config port   : APB-style, pready tied high. 0x0 chunk_bits, 0x4
//                 output_bits, 0x8 lsb_first. Writing output_bits drops any
//                 held bits. Write only while the block is idle.
// Path          : an item taken lands in the input register; its word, if
//                 any, moves into the output register when the merge fires.
// Throughput    : one item per cycle unless stalled, set by the single merge
//                 step between input register and output register / held bits.
// Stall         : while a word waits in the output register, the input
//                 register is held and chunk_ready drops once it is full.
// Reset         : synchronous, active high; registers return to chunk_bits
//                 1, output_bits 8, lsb_first 0, no held bits, no items.
// ----------------------------------------------------------------------------
module unpacked_bits_to_packed_word (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           chunk_valid,
  output logic                           chunk_ready,
  input  logic [ubpw_pkg::CHUNK_W-1:0]   in_chunk,
  // output channel
  output logic                           word_valid,
  input  logic                           word_ready,
  output logic [ubpw_pkg::WORD_W-1:0]    packed_value,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ubpw_pkg::ADDR_W-1:0]    paddr,
  input  logic [ubpw_pkg::DATA_W-1:0]    pwdata,
  output logic [ubpw_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import ubpw_pkg::*;

  // configuration registers
  logic [WID_W-1:0]   chunk_bits;
  logic [WID_W-1:0]   output_bits;
  logic               lsb_first;

  // input register
  logic               s1_valid;
  logic [CHUNK_W-1:0] s1_chunk;

  // stream state
  logic [WORD_W-1:0]  held_bits;
  logic [CNT_W-1:0]   held_count;
  logic [WORD_W-1:0]  held_bits_next;
  logic [CNT_W-1:0]   held_count_next;

  // merge datapath
  logic [WID_W-1:0]     ob_eff;
  logic [WID_W-1:0]     cb_eff;
  logic [CHUNK_W-1:0]   chunk_m;
  logic [2*WORD_W-1:0]  acc;
  logic [WID_W-1:0]     total;
  logic [WID_W-1:0]     rest;
  logic                 word_hit;
  logic [WORD_W-1:0]    word_msb;
  logic [WORD_W-1:0]    word_out;
  logic                 s1_fire;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  // ---- register read ----
  always_comb begin
    case (cfg_idx)
      REG_CHUNK_BITS:  prdata = DATA_W'(chunk_bits);
      REG_OUTPUT_BITS: prdata = DATA_W'(output_bits);
      REG_LSB_FIRST:   prdata = DATA_W'(lsb_first);
      default:         prdata = '0;
    endcase
  end

  // ---- handshakes ----
  // the input register moves on whenever the output register is free or its word is taken
  assign s1_fire     = s1_valid & (~word_valid | word_ready);
  assign chunk_ready = ~s1_valid | s1_fire;

  // ---- merge step ----
  always_comb begin
    ob_eff  = clamp_width(output_bits);
    cb_eff  = clamp_width(chunk_bits);
    if (cb_eff > ob_eff) begin
      cb_eff = ob_eff;             // chunk wider than word: keep low bits
    end
    chunk_m  = s1_chunk & low_mask(cb_eff);
    acc      = ({{WORD_W{1'b0}}, held_bits} << cb_eff) | {{WORD_W{1'b0}}, chunk_m};
    total    = WID_W'(held_count) + cb_eff;
    word_hit = (total >= ob_eff);
    rest     = word_hit ? (total - ob_eff) : total;
    word_msb = WORD_W'(acc >> rest) & low_mask(ob_eff);
    // LSB-first: mirror the whole byte, then drop the unused low positions
    word_out = lsb_first ? (rev_word(word_msb) >> (WID_W'(WORD_W) - ob_eff))
                         : word_msb;
    held_bits_next  = acc[WORD_W-1:0] & low_mask(rest);
    held_count_next = rest[CNT_W-1:0];
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bits  <= WID_W'(1);
      output_bits <= WID_W'(WORD_W);
      lsb_first   <= 1'b0;
      s1_valid    <= 1'b0;
      word_valid  <= 1'b0;
      held_bits   <= '0;
      held_count  <= '0;
    end else begin
      if (chunk_valid && chunk_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        word_valid <= word_hit;
      end else if (word_ready) begin
        word_valid <= 1'b0;
      end

      if (s1_fire) begin
        held_bits  <= held_bits_next;
        held_count <= held_count_next;
      end

      if (cfg_wr) begin
        case (cfg_idx)
          REG_CHUNK_BITS:  chunk_bits <= pwdata[WID_W-1:0];
          REG_OUTPUT_BITS: begin
            output_bits <= pwdata[WID_W-1:0];
            held_bits   <= '0;     // new word width: start afresh
            held_count  <= '0;
          end
          REG_LSB_FIRST:   lsb_first <= pwdata[0];
          default:         ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (chunk_valid && chunk_ready) begin
      s1_chunk <= in_chunk;
    end
    if (s1_fire && word_hit) begin
      packed_value <= word_out;
    end
  end

  // ---- assertions ----
  // held bits never reach a full word
  a_held_below_word: assert property (@(posedge clk) disable iff (rst)
    WID_W'(held_count) < ob_eff)
    else $error("held_count reached output width");

  // an output width write empties the held bits
  a_ob_write_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && cfg_idx == REG_OUTPUT_BITS) |=> (held_count == '0))
    else $error("held bits survived output_bits write");

  // a completed word reaches the output register on the next edge
  a_word_issued: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && word_hit) |=> (word_valid && packed_value == $past(word_out)))
    else $error("completed word not presented");

  // an item that completes no word leaves the output empty
  a_no_word: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !word_hit) |=> !word_valid)
    else $error("word shown for an item that completed none");

  // a waiting word is never overwritten by the merge step
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (word_valid && !word_ready) |-> !s1_fire)
    else $error("merge step fired over a waiting word");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: bit repacker testbench
// Drives bytes through the valid/ready input and checks every packed word on
// the output against an in-bench predictor. A short table of directed rows
// comes first, then randomly configured phases of random bytes, with random
// gaps on both channels and a long output stall to back the block up.
// ----------------------------------------------------------------------------
module tb;

  import ubpw_pkg::*;

  // ---------------------------------------------------------------------------
  // Constants
  // ---------------------------------------------------------------------------
  localparam logic [1:0] REG_UNUSED   = 2'd3;  // beyond the register map, write ignored
  localparam logic [1:0] IDX_NA       = 2'd0;  // index field unused on item rows
  localparam int         SETTLE_CYC   = 4;     // extra wait once the owed words are out
  localparam int         HOLD_CYC     = 80;    // long output stall
  localparam int         RANDOM_ITEMS = 1400;
  localparam int         PLAN_ROWS    = 41;

  typedef enum logic [0:0] {ROW_CFG, ROW_ITEM} row_kind_t;

  // where the expectation of an item row comes from
  typedef enum logic [1:0] {
    EXP_MODEL,  // predictor decides
    EXP_NONE,   // typed in: no word
    EXP_WORD    // typed in: this word
  } exp_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  idx;   // register index on config rows
    logic [31:0] data;  // register value, or the byte on item rows
    exp_kind_t   how;
    logic [7:0]  word;
  } row_t;

  // ---------------------------------------------------------------------------
  // Directed plan
  // ---------------------------------------------------------------------------
  row_t plan [PLAN_ROWS] = '{
    // reset settings: 1-bit chunks, 8-bit words, MSB first; upper bits ignored
    '{ROW_ITEM, IDX_NA,          32'hFF,        EXP_NONE,  8'h00},
    '{ROW_ITEM, IDX_NA,          32'hFE,        EXP_NONE,  8'h00},
    '{ROW_ITEM, IDX_NA,          32'h01,        EXP_NONE,  8'h00},
    '{ROW_ITEM, IDX_NA,          32'h00,        EXP_NONE,  8'h00},
    '{ROW_ITEM, IDX_NA,          32'hFF,        EXP_NONE,  8'h00},
    '{ROW_ITEM, IDX_NA,          32'h81,        EXP_NONE,  8'h00},
    '{ROW_ITEM, IDX_NA,          32'h03,        EXP_NONE,  8'h00},
    '{ROW_ITEM, IDX_NA,          32'h80,        EXP_WORD,  8'hAE},
    // full-byte chunks, junk in the upper data bits
    '{ROW_CFG,  REG_CHUNK_BITS,  32'hFFFF_FFF8, EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'hA5,        EXP_WORD,  8'hA5},
    '{ROW_ITEM, IDX_NA,          32'h00,        EXP_WORD,  8'h00},
    '{ROW_ITEM, IDX_NA,          32'hFF,        EXP_WORD,  8'hFF},
    // LSB first: word comes out bit-reversed
    '{ROW_CFG,  REG_LSB_FIRST,   32'h1,         EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'h01,        EXP_WORD,  8'h80},
    '{ROW_ITEM, IDX_NA,          32'h4B,        EXP_WORD,  8'hD2},
    // output width 0 acts as 1; 8-bit chunk clamped down to the word width
    '{ROW_CFG,  REG_OUTPUT_BITS, 32'h0,         EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'hFE,        EXP_WORD,  8'h00},
    '{ROW_ITEM, IDX_NA,          32'h01,        EXP_WORD,  8'h01},
    // output width 15 acts as 8, chunk width 0 acts as 1
    '{ROW_CFG,  REG_OUTPUT_BITS, 32'hF,         EXP_MODEL, 8'h00},
    '{ROW_CFG,  REG_CHUNK_BITS,  32'h0,         EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'h01,        EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'h00,        EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'hFF,        EXP_MODEL, 8'h00},
    // chunk width 15 acts as 8; held bits carry over the write
    '{ROW_CFG,  REG_CHUNK_BITS,  32'hF,         EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'h5A,        EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'hC3,        EXP_MODEL, 8'h00},
    // write outside the map, then flip bit order with bits still held
    '{ROW_CFG,  REG_UNUSED,      32'h7,         EXP_MODEL, 8'h00},
    '{ROW_CFG,  REG_LSB_FIRST,   32'h8000_0000, EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'h96,        EXP_MODEL, 8'h00},
    // 3-bit words, 5-bit chunk clamped to 3
    '{ROW_CFG,  REG_OUTPUT_BITS, 32'h3,         EXP_MODEL, 8'h00},
    '{ROW_CFG,  REG_CHUNK_BITS,  32'h5,         EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'hFF,        EXP_WORD,  8'h07},
    '{ROW_ITEM, IDX_NA,          32'hF8,        EXP_WORD,  8'h00},
    // 5-bit words from 3-bit chunks; rewriting the width drops held bits
    '{ROW_CFG,  REG_OUTPUT_BITS, 32'h5,         EXP_MODEL, 8'h00},
    '{ROW_CFG,  REG_CHUNK_BITS,  32'h3,         EXP_MODEL, 8'h00},
    '{ROW_CFG,  REG_LSB_FIRST,   32'h1,         EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'h06,        EXP_MODEL, 8'h00},
    '{ROW_CFG,  REG_OUTPUT_BITS, 32'h5,         EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'h05,        EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'h07,        EXP_MODEL, 8'h00},
    '{ROW_ITEM, IDX_NA,          32'hAA,        EXP_MODEL, 8'h00}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset, block ports
  // ---------------------------------------------------------------------------
  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                chunk_valid = 1'b0;
  logic                chunk_ready;
  logic [CHUNK_W-1:0]  in_chunk    = '0;
  logic                word_valid;
  logic                word_ready  = 1'b0;
  logic [WORD_W-1:0]   packed_value;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [DATA_W-1:0]   pwdata      = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  unpacked_bits_to_packed_word dut (
    .clk          (clk),
    .rst          (rst),
    .chunk_valid  (chunk_valid),
    .chunk_ready  (chunk_ready),
    .in_chunk     (in_chunk),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .packed_value (packed_value),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: register copies and the held bit stream
  // ---------------------------------------------------------------------------
  logic [WID_W-1:0]  cfg_chunk_bits  = 4'd1;
  logic [WID_W-1:0]  cfg_output_bits = 4'd8;
  logic              cfg_lsb_first   = 1'b0;
  logic [WORD_W-1:0] held_bits       = '0;   // oldest bit highest
  logic [CNT_W-1:0]  held_count      = '0;

  logic [WORD_W-1:0] pending_words [$];      // words still owed by the block
  int                fail_count = 0;

  bit tx_calm  = 1'b0;  // sender offers back to back
  bit rx_calm  = 1'b0;  // receiver always ready
  bit hold_req = 1'b0;  // ask the receiver for a long stall

  // out-of-range widths: 0 behaves as 1, anything above 8 as 8
  function automatic logic [WID_W-1:0] legal_width(input logic [WID_W-1:0] w);
    return (w == 4'd0) ? 4'd1 : ((w > 4'd8) ? 4'd8 : w);
  endfunction

  function automatic logic [15:0] ones_below(input logic [WID_W-1:0] n);
    return (16'd1 << n) - 16'd1;
  endfunction

  // Feeds one byte into the stream; returns 1 with the word when one is due.
  function automatic bit repack_byte(input logic [7:0] in_byte, output logic [7:0] word);
    logic [WID_W-1:0] ob;
    logic [WID_W-1:0] cb;
    logic [WID_W-1:0] total;
    logic [WID_W-1:0] rest;
    logic [15:0]      acc;
    logic [7:0]       raw;
    logic [7:0]       flipped;
    ob = legal_width(cfg_output_bits);
    cb = legal_width(cfg_chunk_bits);
    if (cb > ob) cb = ob;  // chunk never wider than the word
    acc   = ({8'h00, held_bits} << cb) | ({8'h00, in_byte} & ones_below(cb));
    total = {1'b0, held_count} + cb;
    word  = 8'h00;
    if (total < ob) begin
      held_bits  = acc[7:0];
      held_count = total[2:0];
      return 1'b0;
    end
    rest    = total - ob;
    raw     = 8'((acc >> rest) & ones_below(ob));
    flipped = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (i < ob) flipped[ob - 1 - i] = raw[i];
    end
    held_bits  = 8'(acc & ones_below(rest));
    held_count = rest[2:0];
    word       = cfg_lsb_first ? flipped : raw;
    return 1'b1;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Tasks start and end just after a falling edge.
  // ---------------------------------------------------------------------------
  task automatic push_chunk(input logic [7:0] value, input exp_kind_t how,
                            input logic [7:0] typed);
    int         gap;
    bit         emits;
    logic [7:0] word;
    gap = tx_calm ? 0 : idle_gap();
    if (gap > 0) begin
      chunk_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    chunk_valid = 1'b1;
    in_chunk    = value;
    do @(posedge clk); while (!chunk_ready);
    // item taken at this edge: advance the predictor
    emits = repack_byte(value, word);
    case (how)
      EXP_MODEL: if (emits) pending_words.push_back(word);
      EXP_WORD:  pending_words.push_back(typed);
      default:   ;
    endcase
    @(negedge clk);
  endtask

  // Stop offering, let every owed word out, then let the block go quiet.
  task automatic settle_block();
    chunk_valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CHUNK_BITS:  cfg_chunk_bits = data[3:0];
      REG_OUTPUT_BITS: begin
        cfg_output_bits = data[3:0];
        held_bits       = '0;  // width change drops the partial word
        held_count      = '0;
      end
      REG_LSB_FIRST:   cfg_lsb_first = data[0];
      default:         ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // width value: extremes and out-of-range codes well represented,
  // upper data bits random
  function automatic logic [31:0] width_value();
    logic [31:0] d;
    d = $urandom();
    case ($urandom_range(0, 5))
      0:       d[3:0] = 4'd0;
      1:       d[3:0] = 4'd1;
      2:       d[3:0] = 4'd8;
      3:       d[3:0] = 4'($urandom_range(9, 15));
      default: d[3:0] = 4'($urandom_range(1, 8));
    endcase
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and the long hold on request.
  // The hold is counted here, independent of what the sender is doing.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYC;
      end else if (stall == 0 && !rx_calm && $urandom_range(0, 2) == 0) begin
        stall = idle_gap();
      end
      word_ready = (stall == 0);
      if (stall > 0) stall--;
    end
  end

  // ---------------------------------------------------------------------------
  // Output checker: each word taken is matched against the oldest owed word
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] owed;

  always @(posedge clk) begin
    if (!rst && word_valid && word_ready) begin
      if (pending_words.size() == 0) begin
        $error("packed_value: expected none, got %02h", packed_value);
        fail_count++;
      end else begin
        owed = pending_words.pop_front();
        if (packed_value !== owed) begin
          $error("packed_value: expected %02h, got %02h", owed, packed_value);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          sent;
    int          phase;
    int          len;
    logic [1:0]  idx;
    logic [31:0] d;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table; config rows wait for the block to drain first
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_CFG) begin
        settle_block();
        apb_write(plan[r].idx, plan[r].data);
      end else begin
        push_chunk(plan[r].data[7:0], plan[r].how, plan[r].word);
      end
    end

    // random phases: reconfigure while idle, then a burst of random bytes
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle_block();
      if (phase % 9 == 4) begin
        // full chunks give one word per item, so the stall backs up the input
        d      = $urandom();
        d[3:0] = 4'd8;
        apb_write(REG_CHUNK_BITS, d);
        tx_calm  = 1'b1;
        hold_req = 1'b1;
        len      = 60;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          idx = 2'($urandom_range(0, 3));
          d   = (idx == REG_CHUNK_BITS || idx == REG_OUTPUT_BITS) ? width_value()
                                                                 : $urandom();
          apb_write(idx, d);
        end
        tx_calm = ($urandom_range(0, 3) == 0);
        len     = $urandom_range(10, 100);
      end
      repeat (len) push_chunk(8'($urandom_range(0, 255)), EXP_MODEL, 8'h00);
      sent += len;
      phase++;
    end

    settle_block();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("unpacked_bits_to_packed_word verification clean");
    end else begin
      $display("unpacked_bits_to_packed_word verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20ms;
    $display("unpacked_bits_to_packed_word verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ubpw_pkg.sv
src/unpacked_bits_to_packed_word.sv
tb/tb.sv
